[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/mtsd_pkg.sv]
// ----------------------------------------------------------------------------
// mtsd_pkg
// Types, constants and tree ROM functions for the Morse tree symbol decoder.
// ----------------------------------------------------------------------------
package mtsd_pkg;

    // Field widths.
    localparam int unsigned CODE_W = 5;
    localparam int unsigned NODE_W = 7;
    localparam int unsigned MASK_W = 16;

    // Tree size and special nodes.
    localparam logic [NODE_W-1:0] ROOT_NODE  = 7'd0;
    localparam logic [NODE_W-1:0] TREE_NODES = 7'd67;

    // Valid range of transition codes.
    localparam logic [CODE_W-1:0] CODE_MIN = 5'd1;
    localparam logic [CODE_W-1:0] CODE_MAX = 5'd16;

    // Reset value of the key level mask.
    localparam logic [MASK_W-1:0] MASK_RESET = 16'h00FF;

    // What a transition code does to the tree walk.
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_DIT,
        ACT_DAH,
        ACT_CHAR,
        ACT_WORD
    } t_action;

    // Decode a transition code into its tree action.
    function automatic t_action code_action(input logic [CODE_W-1:0] code);
        t_action act;
        act = ACT_NONE;
        unique case (code)
            5'd9, 5'd11, 5'd13, 5'd15:   act = ACT_DIT;
            5'd10, 5'd12, 5'd14, 5'd16:  act = ACT_DAH;
            5'd2, 5'd6:                  act = ACT_CHAR;
            5'd3, 5'd4, 5'd7, 5'd8:      act = ACT_WORD;
            default:                     act = ACT_NONE;
        endcase
        return act;
    endfunction

    // Dit link of the tree ROM; zero means no child.
    function automatic logic [NODE_W-1:0] dit_link(input logic [NODE_W-1:0] node);
        logic [NODE_W-1:0] nxt;
        nxt = ROOT_NODE;
        if (node <= 7'd28) begin
            nxt = {node[NODE_W-2:0], 1'b1};
        end else begin
            unique case (node)
                7'd29:   nxt = 7'd54;
                7'd30:   nxt = 7'd56;
                7'd37:   nxt = 7'd58;
                7'd44:   nxt = 7'd59;
                7'd46:   nxt = 7'd66;
                7'd48:   nxt = 7'd61;
                default: nxt = ROOT_NODE;
            endcase
        end
        return nxt;
    endfunction

    // Dah link of the tree ROM; zero means no child.
    function automatic logic [NODE_W-1:0] dah_link(input logic [NODE_W-1:0] node);
        logic [NODE_W-1:0] nxt;
        nxt = ROOT_NODE;
        if (node <= 7'd25) begin
            nxt = {node[NODE_W-2:0], 1'b0} + 7'd2;
        end else begin
            unique case (node)
                7'd30:   nxt = 7'd57;
                7'd33:   nxt = 7'd60;
                7'd41:   nxt = 7'd63;
                7'd61:   nxt = 7'd62;
                7'd64:   nxt = 7'd65;
                default: nxt = ROOT_NODE;
            endcase
        end
        return nxt;
    endfunction

endpackage

[rtl/morse_tree_symbol_decoder_top.sv]
// ----------------------------------------------------------------------------
// morse_tree_symbol_decoder_top
// Walks the dit/dah Morse tree one transition code at a time and reports
// completed symbols as tree node numbers.
//
//   Channel  Direction  Handshake              Payload
//   input    in         i_valid / o_stall      i_transition_code
//   result   out        o_valid / i_stall      o_next_node, o_emit_symbol,
//                                              o_symbol_node, o_append_space
//   config   in         i_cfg_we               i_cfg_data
//
// One word is accepted every cycle while o_stall is low; its result passes
// through the input register, then the result register, before it is
// offered on the result channel.
// The tree ROM lookup and the key level compare sit between those registers.
// Reset returns the walk to the root, clears the key level and loads the
// mask with 0x00FF.
// A stall on the result side holds the result register and, once the input
// register is also full, raises o_stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module morse_tree_symbol_decoder_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input channel.
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [mtsd_pkg::CODE_W-1:0]   i_transition_code,
    // Result channel.
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [mtsd_pkg::NODE_W-1:0]   o_next_node,
    output logic                          o_emit_symbol,
    output logic [mtsd_pkg::NODE_W-1:0]   o_symbol_node,
    output logic                          o_append_space,
    // Configuration.
    input  logic                          i_cfg_we,
    input  logic [mtsd_pkg::MASK_W-1:0]   i_cfg_data
);

    // Input register.
    logic                          r_in_valid;
    logic [mtsd_pkg::CODE_W-1:0]   r_in_code;

    // Walk state and configuration.
    logic [mtsd_pkg::NODE_W-1:0]   r_node;
    logic [mtsd_pkg::NODE_W-1:0]   n_node;
    logic                          r_level;
    logic                          n_level;
    logic [mtsd_pkg::MASK_W-1:0]   r_mask;

    // Result register.
    logic                          r_out_valid;
    logic [mtsd_pkg::NODE_W-1:0]   r_out_next_node;
    logic                          r_out_emit;
    logic [mtsd_pkg::NODE_W-1:0]   r_out_sym;
    logic                          r_out_space;

    // Step logic.
    logic                          out_free;
    logic                          advance;
    logic                          in_take;
    logic                          code_ok;
    logic [3:0]                    mask_idx;
    logic                          code_level;
    mtsd_pkg::t_action             act;
    logic                          n_emit;
    logic [mtsd_pkg::NODE_W-1:0]   n_sym;
    logic                          n_space;

    // Handshake: the result register frees up when empty or being taken.
    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign in_take  = i_valid && (!r_in_valid || advance);
    assign o_stall  = r_in_valid && !advance;

    // Key level of the held code, taken from the mask.
    always_comb begin
        code_ok    = (r_in_code >= mtsd_pkg::CODE_MIN) && (r_in_code <= mtsd_pkg::CODE_MAX);
        mask_idx   = 4'(r_in_code - 5'd1);
        code_level = r_mask[mask_idx];
        act        = mtsd_pkg::code_action(r_in_code);
    end

    // Next node, key level and emitted symbol for the held code.
    always_comb begin
        n_node  = r_node;
        n_level = r_level;
        n_emit  = 1'b0;
        n_sym   = mtsd_pkg::ROOT_NODE;
        n_space = 1'b0;
        if (code_ok) begin
            n_level = code_level;
            if (r_node >= mtsd_pkg::TREE_NODES) begin
                n_node = mtsd_pkg::ROOT_NODE;
            end else if (code_level != r_level) begin
                unique case (act)
                    mtsd_pkg::ACT_DIT: begin
                        n_node = mtsd_pkg::dit_link(r_node);
                    end
                    mtsd_pkg::ACT_DAH: begin
                        n_node = mtsd_pkg::dah_link(r_node);
                    end
                    mtsd_pkg::ACT_CHAR: begin
                        n_emit = 1'b1;
                        n_sym  = r_node;
                        n_node = mtsd_pkg::ROOT_NODE;
                    end
                    mtsd_pkg::ACT_WORD: begin
                        n_emit  = 1'b1;
                        n_sym   = r_node;
                        n_space = 1'b1;
                        n_node  = mtsd_pkg::ROOT_NODE;
                    end
                    default: begin
                        n_node = r_node;
                    end
                endcase
            end
        end
    end

    // Control registers: valids, walk state and the key level mask.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_node      <= mtsd_pkg::ROOT_NODE;
            r_level     <= 1'b0;
            r_mask      <= mtsd_pkg::MASK_RESET;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_node      <= n_node;
                r_level     <= n_level;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_mask <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_code <= i_transition_code;
        end
        if (advance) begin
            r_out_next_node <= n_node;
            r_out_emit      <= n_emit;
            r_out_sym       <= n_sym;
            r_out_space     <= n_space;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_next_node    = r_out_next_node;
    assign o_emit_symbol  = r_out_emit;
    assign o_symbol_node  = r_out_sym;
    assign o_append_space = r_out_space;

    // Checks on the walk and the result register.
    `ASSERT_ALWAYS(a_node_in_tree, i_clk, i_rst_n, r_node < mtsd_pkg::TREE_NODES)
    `ASSERT_IMPL(a_emit_at_root, i_clk, i_rst_n, r_out_valid && r_out_emit,
                 r_out_next_node == mtsd_pkg::ROOT_NODE)
    `ASSERT_IMPL(a_space_needs_emit, i_clk, i_rst_n, r_out_valid && r_out_space, r_out_emit)
    `ASSERT_NEXT(a_emit_resets_walk, i_clk, i_rst_n, advance && n_emit,
                 r_node == mtsd_pkg::ROOT_NODE && r_out_valid)

endmodule
